### rtl/core/sabi_pkg.sv
// shared types, constants and register codes for the segment/box slab test
package sabi_pkg;

    // coordinate and slab parameter formats
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int T_FRAC          = 32;
    localparam int T_W             = T_FRAC + 3;
    localparam int PROD_W          = 2 * T_FRAC;

    // pipeline depths of the shared units
    localparam int DIV_STAGES  = T_FRAC + 1;
    localparam int LERP_STAGES = 3;

    // configuration register file
    localparam int                 THR_W       = 16;
    localparam logic [THR_W-1:0]   THR_RESET   = 16'd1;
    localparam int                 APB_AW      = 3;
    localparam int                 APB_DW      = 32;
    localparam int                 REG_IDX_W   = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_PAR_THR = '0;

    // entered face
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // input item
    typedef struct packed {
        logic signed [FIELD_W-1:0] seg_start_x;
        logic signed [FIELD_W-1:0] seg_start_y;
        logic signed [FIELD_W-1:0] seg_start_z;
        logic signed [FIELD_W-1:0] seg_end_x;
        logic signed [FIELD_W-1:0] seg_end_y;
        logic signed [FIELD_W-1:0] seg_end_z;
        logic signed [FIELD_W-1:0] box_min_x;
        logic signed [FIELD_W-1:0] box_min_y;
        logic signed [FIELD_W-1:0] box_min_z;
        logic signed [FIELD_W-1:0] box_max_x;
        logic signed [FIELD_W-1:0] box_max_y;
        logic signed [FIELD_W-1:0] box_max_z;
    } in_item_t;

    // result item
    typedef struct packed {
        logic                      hit;
        axis_t                     entry_axis;
        logic signed [FIELD_W-1:0] hit_x;
        logic signed [FIELD_W-1:0] hit_y;
        logic signed [FIELD_W-1:0] hit_z;
        logic signed [FIELD_W-1:0] depth_x;
        logic signed [FIELD_W-1:0] depth_y;
        logic signed [FIELD_W-1:0] depth_z;
    } out_item_t;

endpackage

### rtl/core/sabi_div.sv
// pipelined restoring divider: slab parameter num/den, 32 fraction bits, saturated to +-2
module sabi_div #(
    parameter int CW = sabi_pkg::COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic [sabi_pkg::DIV_STAGES-1:0]   en,
    input  logic signed [CW-1:0]              num,
    input  logic signed [CW-1:0]              den,
    output logic signed [sabi_pkg::T_W-1:0]   quo
);
    import sabi_pkg::*;

    localparam int QW = T_FRAC + 1;
    localparam logic [T_W-1:0] T_SAT = T_W'(1) << (T_FRAC + 1);

    logic [CW-1:0] rem_reg [DIV_STAGES];
    logic [CW-1:0] dsr_reg [DIV_STAGES];
    logic [QW-1:0] q_reg   [DIV_STAGES];
    logic          neg_reg [DIV_STAGES];
    logic          sat_reg [DIV_STAGES];

    logic [CW-1:0] n_mag;
    logic [CW-1:0] d_mag;
    logic          ip;
    logic          sat;
    logic [T_W-1:0] mq;

    // magnitudes, saturation check and integer bit
    always_comb begin
        n_mag = num[CW-1] ? CW'(~num + 1'b1) : CW'(num);
        d_mag = den[CW-1] ? CW'(~den + 1'b1) : CW'(den);
        ip    = n_mag >= d_mag;
        sat   = {1'b0, n_mag} >= {d_mag, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= ip ? CW'(n_mag - d_mag) : n_mag;
            dsr_reg[0] <= d_mag;
            q_reg[0]   <= QW'(ip);
            neg_reg[0] <= num[CW-1] ^ den[CW-1];
            sat_reg[0] <= sat;
        end
    end

    // one quotient bit a stage
    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
        logic [CW:0] r2;
        logic        ge;
        always_comb begin
            r2 = {rem_reg[k-1], 1'b0};
            ge = r2 >= {1'b0, dsr_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= ge ? CW'(r2 - {1'b0, dsr_reg[k-1]}) : CW'(r2);
                dsr_reg[k] <= dsr_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    // sign and saturation
    always_comb begin
        mq  = sat_reg[DIV_STAGES-1] ? T_SAT : T_W'(q_reg[DIV_STAGES-1]);
        quo = neg_reg[DIV_STAGES-1] ? signed'(T_W'(~mq + 1'b1)) : signed'(mq);
    end

endmodule

### rtl/core/sabi_lerp.sv
// three-stage point on segment: s + d*t, product rounded half away from zero, saturated
module sabi_lerp #(
    parameter int CW = sabi_pkg::COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic [sabi_pkg::LERP_STAGES-1:0]  en,
    input  logic signed [CW-1:0]              s,
    input  logic signed [CW-1:0]              d,
    input  logic signed [sabi_pkg::T_W-1:0]   t,
    output logic signed [CW-1:0]              pnt
);
    import sabi_pkg::*;

    localparam logic signed [CW+1:0] CMAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] CMIN = {3'b111, {(CW-1){1'b0}}};

    logic [CW-1:0]     m;
    logic [PROD_W-1:0] m_ext;

    logic [PROD_W-1:0] ph_reg;
    logic [PROD_W-1:0] pl_reg;
    logic              full_reg;
    logic [CW-1:0]     m_reg;
    logic signed [CW-1:0] s0_reg;
    logic              neg0_reg;

    logic [PROD_W:0]   pl_rnd;
    logic [PROD_W-1:0] p_sum;
    logic [CW-1:0]     p_reg;
    logic signed [CW-1:0] s1_reg;
    logic              neg1_reg;

    logic signed [CW:0]   term;
    logic signed [CW+1:0] total;
    logic signed [CW-1:0] pnt_reg;

    // split magnitude into high and low halves, multiply each by t
    always_comb begin
        m     = d[CW-1] ? CW'(~d + 1'b1) : CW'(d);
        m_ext = PROD_W'(m);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ph_reg   <= PROD_W'(m_ext[PROD_W-1:T_FRAC] * t[T_FRAC-1:0]);
            pl_reg   <= PROD_W'(m_ext[T_FRAC-1:0] * t[T_FRAC-1:0]);
            full_reg <= t[T_FRAC];
            m_reg    <= m;
            s0_reg   <= s;
            neg0_reg <= d[CW-1];
        end
    end

    // round the low partial product and combine
    always_comb begin
        pl_rnd = {1'b0, pl_reg} + ((PROD_W+1)'(1) << (T_FRAC - 1));
        p_sum  = ph_reg + PROD_W'(pl_rnd[PROD_W:T_FRAC]);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p_reg    <= full_reg ? m_reg : CW'(p_sum);
            s1_reg   <= s0_reg;
            neg1_reg <= neg0_reg;
        end
    end

    // signed add to start, saturating
    always_comb begin
        term  = neg1_reg ? signed'((CW+1)'(~{1'b0, p_reg} + 1'b1)) : signed'({1'b0, p_reg});
        total = (CW+2)'(s1_reg) + (CW+2)'(term);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            if (total > CMAX) begin
                pnt_reg <= CMAX[CW-1:0];
            end else if (total < CMIN) begin
                pnt_reg <= CMIN[CW-1:0];
            end else begin
                pnt_reg <= total[CW-1:0];
            end
        end
    end

    assign pnt = pnt_reg;

endmodule

### rtl/core/segment_aabb_slab_intersect.sv
// top level: segment versus axis-aligned box slab test, fully pipelined
//
//  port group   direction  handshake          item
//  s_*          in         s_valid/s_ready    sabi_pkg::in_item_t
//  m_*          out        m_valid/m_ready    sabi_pkg::out_item_t
//  p*           in/out     apb, pready tied   parallel_threshold at byte address 0
//
// one item enters per cycle unless m_ready holds back a full pipeline; an accepted item reaches m_valid
// through 40 register stages: prep, 33-stage divider, near/far, clip, 3 lerp and output
// stages hold valid bits; a stalled output stage lets earlier bubbles close up, nothing is lost
// aresetn clears the valid bits and sets parallel_threshold to 1
module segment_aabb_slab_intersect #(
    parameter int COORD_WIDTH = sabi_pkg::COORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sabi_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sabi_pkg::out_item_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sabi_pkg::APB_AW-1:0]    paddr,
    input  logic [sabi_pkg::APB_DW-1:0]    pwdata,
    output logic [sabi_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import sabi_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int WW = ((CW > FIELD_W) ? CW : FIELD_W) + 2;
    localparam logic signed [WW-1:0] CMAXW = (WW'(1) << (CW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] CMINW = ~CMAXW;
    localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    // stage map
    localparam int ST_DIV0  = 1;
    localparam int ST_LOHI  = ST_DIV0 + DIV_STAGES;
    localparam int ST_CLIP  = ST_LOHI + 1;
    localparam int ST_LERP0 = ST_CLIP + 1;
    localparam int ST_OUT   = ST_LERP0 + LERP_STAGES;
    localparam int NST      = ST_OUT + 1;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] dv;
        logic [2:0][CW-1:0] face;
        logic [2:0]         par;
        logic               pmiss;
    } side_t;

    typedef struct packed {
        logic               hit;
        axis_t              axis;
        logic [2:0][CW-1:0] face;
    } meta_t;

    function automatic logic signed [CW-1:0] clampw(input logic signed [WW-1:0] v);
        if (v > CMAXW) begin
            return CMAXW[CW-1:0];
        end else if (v < CMINW) begin
            return CMINW[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] fld(input logic signed [FIELD_W-1:0] raw);
        return clampw(WW'(raw));
    endfunction

    function automatic logic signed [CW-1:0] ssub(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return clampw(WW'(a) - WW'(b));
    endfunction

    logic [THR_W-1:0] thr_reg;
    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   en;

    side_t            side_reg [ST_CLIP+1];
    logic [CW-1:0]    num_reg  [3][2];
    logic signed [T_W-1:0] t_div [3][2];
    logic signed [T_W-1:0] lo_reg [3];
    logic signed [T_W-1:0] hi_reg [3];
    logic signed [T_W-1:0] tmin_reg;
    logic signed [T_W-1:0] tmax_reg;
    logic             hit_reg;
    axis_t            axis_reg;
    meta_t            meta_reg [LERP_STAGES];
    logic signed [CW-1:0] lmin [3];
    logic signed [CW-1:0] lmax [3];
    out_item_t        out_reg;

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_PAR_THR) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end
    assign prdata = (paddr[APB_AW-1:2] == REG_PAR_THR) ? APB_DW'(thr_reg) : '0;

    // stage advance chain: a stage loads when empty or when it is moving on
    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end
    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // prep: direction, slab offsets, parallel and outside flags, face values
    logic signed [CW-1:0] sv [3];
    logic signed [CW-1:0] ev [3];
    logic signed [CW-1:0] mn [3];
    logic signed [CW-1:0] mx [3];
    logic signed [CW-1:0] dvv [3];
    logic [CW-1:0]        dmag [3];
    side_t                prep;

    always_comb begin
        sv[0] = fld(s_data.seg_start_x);
        sv[1] = fld(s_data.seg_start_y);
        sv[2] = fld(s_data.seg_start_z);
        ev[0] = fld(s_data.seg_end_x);
        ev[1] = fld(s_data.seg_end_y);
        ev[2] = fld(s_data.seg_end_z);
        mn[0] = fld(s_data.box_min_x);
        mn[1] = fld(s_data.box_min_y);
        mn[2] = fld(s_data.box_min_z);
        mx[0] = fld(s_data.box_max_x);
        mx[1] = fld(s_data.box_max_y);
        mx[2] = fld(s_data.box_max_z);
        prep.pmiss = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dvv[i]  = ssub(ev[i], sv[i]);
            dmag[i] = dvv[i][CW-1] ? CW'(~dvv[i] + 1'b1) : CW'(dvv[i]);
            prep.s[i]    = sv[i];
            prep.dv[i]   = dvv[i];
            prep.face[i] = (dvv[i] > 0) ? mn[i] : mx[i];
            prep.par[i]  = WW'(dmag[i]) < WW'(thr_reg);
            if (prep.par[i] && (sv[i] < mn[i] || sv[i] > mx[i])) begin
                prep.pmiss = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= prep;
            for (int i = 0; i < 3; i++) begin
                num_reg[i][0] <= ssub(mn[i], sv[i]);
                num_reg[i][1] <= ssub(mx[i], sv[i]);
            end
        end
    end

    // side data travels alongside the dividers up to the clip stage
    for (genvar j = 1; j <= ST_CLIP; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en[j]) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // two slab dividers per axis
    for (genvar i = 0; i < 3; i++) begin : g_axis
        for (genvar b = 0; b < 2; b++) begin : g_bound
            sabi_div #(.CW(CW)) u_div (
                .aclk (aclk),
                .en   (en[ST_DIV0 +: DIV_STAGES]),
                .num  (num_reg[i][b]),
                .den  (side_reg[0].dv[i]),
                .quo  (t_div[i][b])
            );
        end
    end

    // near and far slab parameters
    always_ff @(posedge aclk) begin
        if (en[ST_LOHI]) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= (t_div[i][0] > t_div[i][1]) ? t_div[i][1] : t_div[i][0];
                hi_reg[i] <= (t_div[i][0] > t_div[i][1]) ? t_div[i][0] : t_div[i][1];
            end
        end
    end

    // clip [0,1] over the three axes, first axis wins a tie on entry
    logic signed [T_W-1:0] tmin_c;
    logic signed [T_W-1:0] tmax_c;
    axis_t                 axis_c;

    always_comb begin
        tmin_c = '0;
        tmax_c = T_ONE;
        axis_c = AXIS_NONE;
        for (int i = 0; i < 3; i++) begin
            if (!side_reg[ST_LOHI].par[i]) begin
                if (lo_reg[i] > tmin_c) begin
                    tmin_c = lo_reg[i];
                    axis_c = axis_t'(2'(i));
                end
                if (hi_reg[i] < tmax_c) begin
                    tmax_c = hi_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_CLIP]) begin
            tmin_reg <= tmin_c;
            tmax_reg <= tmax_c;
            axis_reg <= axis_c;
            hit_reg  <= !(side_reg[ST_LOHI].pmiss || tmin_c > tmax_c);
        end
    end

    // entry and exit points
    for (genvar i = 0; i < 3; i++) begin : g_pt
        sabi_lerp #(.CW(CW)) u_lerp_in (
            .aclk (aclk),
            .en   (en[ST_LERP0 +: LERP_STAGES]),
            .s    (side_reg[ST_CLIP].s[i]),
            .d    (side_reg[ST_CLIP].dv[i]),
            .t    (tmin_reg),
            .pnt  (lmin[i])
        );
        sabi_lerp #(.CW(CW)) u_lerp_out (
            .aclk (aclk),
            .en   (en[ST_LERP0 +: LERP_STAGES]),
            .s    (side_reg[ST_CLIP].s[i]),
            .d    (side_reg[ST_CLIP].dv[i]),
            .t    (tmax_reg),
            .pnt  (lmax[i])
        );
    end

    for (genvar k = 0; k < LERP_STAGES; k++) begin : g_meta
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[ST_LERP0]) begin
                    meta_reg[0] <= '{hit: hit_reg, axis: axis_reg,
                                     face: side_reg[ST_CLIP].face};
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en[ST_LERP0 + k]) begin
                    meta_reg[k] <= meta_reg[k-1];
                end
            end
        end
    end

    // face override, depth, miss blanking
    logic signed [CW-1:0]      hp  [3];
    logic signed [CW-1:0]      dep [3];
    logic signed [FIELD_W-1:0] hpo [3];
    logic signed [FIELD_W-1:0] dpo [3];
    out_item_t                 out_c;
    meta_t                     mt;

    always_comb begin
        mt = meta_reg[LERP_STAGES-1];
        for (int i = 0; i < 3; i++) begin
            hp[i]  = (mt.axis == axis_t'(2'(i))) ? signed'(mt.face[i]) : lmin[i];
            dep[i] = ssub(lmax[i], hp[i]);
            hpo[i] = mt.hit ? FIELD_W'(WW'(hp[i])) : '0;
            dpo[i] = mt.hit ? FIELD_W'(WW'(dep[i])) : '0;
        end
        out_c.hit        = mt.hit;
        out_c.entry_axis = mt.hit ? mt.axis : AXIS_X;
        out_c.hit_x      = hpo[0];
        out_c.hit_y      = hpo[1];
        out_c.hit_z      = hpo[2];
        out_c.depth_x    = dpo[0];
        out_c.depth_y    = dpo[1];
        out_c.depth_z    = dpo[2];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg <= out_c;
        end
    end

    assign m_valid = v_reg[ST_OUT];
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // a miss carries no coordinates
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.entry_axis == AXIS_X && m_data.hit_x == '0 &&
        m_data.hit_y == '0 && m_data.hit_z == '0 && m_data.depth_x == '0 &&
        m_data.depth_y == '0 && m_data.depth_z == '0))
        else $error("miss result carries non-zero fields");

    // an empty output stage never holds back the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[ST_OUT] |-> s_ready)
        else $error("input stalled with an empty output stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && v_reg == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

### verif/tb_segment_aabb_slab_intersect.sv
// testbench for the segment versus axis-aligned box slab test
module tb_segment_aabb_slab_intersect;
    import sabi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY   = 40;
    localparam int  WDOG_MAX  = 20000;
    localparam int  N_RANDOM  = 1200;
    localparam longint CMAX   = 64'sd2147483647;
    localparam longint CMIN   = -64'sd2147483648;
    localparam longint T_UNIT = 64'sd1 << 32;
    localparam longint T_CAP  = 64'sd1 << 33;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    segment_aabb_slab_intersect dut (.*);

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of the threshold register
    logic [THR_W-1:0] thr_shadow = THR_RESET;
    out_item_t        pending_hits[$];
    int               fail_count = 0;
    int               idle_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    function automatic longint sat_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // quotient with 32 fractional bits, truncated, clipped to +-2
    function automatic longint slab_param(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = abs64(num);
        d = abs64(den);
        if (n >= 2 * d) q = T_CAP;
        else q = longint'((128'(n) << 32) / 128'(d));
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // s + d*t, product rounded half away from zero
    function automatic longint along_seg(longint s, longint d, longint t);
        longint m;
        longint p;
        m = abs64(d);
        if (t >= T_UNIT) p = m;
        else p = longint'(((128'(m) * 128'(t)) + 128'h8000_0000) >> 32);
        return sat_coord(s + (d < 0 ? -p : p));
    endfunction

    function automatic out_item_t slab_clip(in_item_t it);
        longint st[3], dv[3], lo[3], hi[3], hp[3];
        longint tmin, tmax, t1, t2, tx, ex;
        axis_t  ax;
        bit     negface, miss;
        out_item_t r;
        st = '{it.seg_start_x, it.seg_start_y, it.seg_start_z};
        dv = '{sat_coord(longint'(it.seg_end_x) - st[0]),
               sat_coord(longint'(it.seg_end_y) - st[1]),
               sat_coord(longint'(it.seg_end_z) - st[2])};
        lo = '{it.box_min_x, it.box_min_y, it.box_min_z};
        hi = '{it.box_max_x, it.box_max_y, it.box_max_z};
        tmin = 0;
        tmax = T_UNIT;
        ax = AXIS_NONE;
        negface = 0;
        miss = 0;
        r = '0;
        for (int i = 0; i < 3 && !miss; i++) begin
            if (abs64(dv[i]) < longint'(thr_shadow)) begin
                if (st[i] < lo[i] || st[i] > hi[i]) miss = 1;
            end else begin
                t1 = slab_param(sat_coord(lo[i] - st[i]), dv[i]);
                t2 = slab_param(sat_coord(hi[i] - st[i]), dv[i]);
                if (t1 > t2) begin
                    tx = t1; t1 = t2; t2 = tx;
                end
                if (t1 > tmin) begin
                    tmin = t1;
                    ax = axis_t'(i);
                    negface = dv[i] > 0;
                end
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) miss = 1;
            end
        end
        if (miss) return r;
        for (int i = 0; i < 3; i++) hp[i] = along_seg(st[i], dv[i], tmin);
        if (ax != AXIS_NONE) hp[ax] = negface ? lo[ax] : hi[ax];
        r.hit = 1'b1;
        r.entry_axis = ax;
        r.hit_x = hp[0][31:0];
        r.hit_y = hp[1][31:0];
        r.hit_z = hp[2][31:0];
        ex = along_seg(st[0], dv[0], tmax);
        r.depth_x = 32'(sat_coord(ex - hp[0]));
        ex = along_seg(st[1], dv[1], tmax);
        r.depth_y = 32'(sat_coord(ex - hp[1]));
        ex = along_seg(st[2], dv[2], tmax);
        r.depth_z = 32'(sat_coord(ex - hp[2]));
        return r;
    endfunction

    // apb write of the threshold register, block idle
    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_PAR_THR, 2'b00}; pwdata <= APB_DW'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thr_shadow = v;
    endtask

    // send one item, with optional expected result typed in
    task automatic send_item(in_item_t it, bit have_exp, out_item_t exp_r);
        while (($urandom % 100) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hits.push_back(have_exp ? exp_r : slab_clip(it));
    endtask

    // receiver stalls and result check
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_hits.size() == 0) begin
                    $display("%0t unexpected item: actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    e = pending_hits.pop_front();
                    if (m_data.hit !== e.hit || m_data.entry_axis !== e.entry_axis ||
                        m_data.hit_x !== e.hit_x || m_data.hit_y !== e.hit_y ||
                        m_data.hit_z !== e.hit_z || m_data.depth_x !== e.depth_x ||
                        m_data.depth_y !== e.depth_y || m_data.depth_z !== e.depth_z) begin
                        $display("%0t mismatch: expected %h actual %h", $time, e, m_data);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom % 100) >= recv_stall_pct;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom % 6)
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    // box mostly well-formed, segment mostly nearby
    function automatic in_item_t rand_item();
        in_item_t it;
        logic [31:0] a, b;
        it = '0;
        for (int i = 0; i < 12; i++) it[i*32 +: 32] = rand_coord();
        if (($urandom % 10) < 8) begin
            for (int i = 0; i < 3; i++) begin
                a = it[(5-i)*32 +: 32];
                b = it[(2-i)*32 +: 32];
                if ($signed(a) > $signed(b)) begin
                    it[(5-i)*32 +: 32] = b;
                    it[(2-i)*32 +: 32] = a;
                end
                // occasional axis-parallel segment
                if (($urandom % 8) == 0)
                    it[(8-i)*32 +: 32] = it[(11-i)*32 +: 32] + $urandom_range(0, 3);
            end
        end
        return it;
    endfunction

    function automatic in_item_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                    int nx, int ny, int nz, int xx, int xy, int xz);
        in_item_t it;
        it = '{sx, sy, sz, ex, ey, ez, nx, ny, nz, xx, xy, xz};
        return it;
    endfunction

    localparam int ONE = 1 << 16;
    in_item_t  dir_items[$];
    out_item_t dir_exp[$];
    bit        dir_has_exp[$];
    out_item_t miss_r;
    out_item_t inside_r;

    initial begin
        miss_r = '0;
        inside_r = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table: misses and start-inside are typed in
        dir_items.push_back(mk(5*ONE, 0, 0, 6*ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_exp.push_back(miss_r); dir_has_exp.push_back(1);
        dir_items.push_back(mk(5*ONE, 0, 0, 5*ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_exp.push_back(miss_r); dir_has_exp.push_back(1);
        dir_items.push_back(mk(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
        dir_exp.push_back(miss_r); dir_has_exp.push_back(1);
        inside_r.hit = 1'b1; inside_r.entry_axis = AXIS_NONE;
        dir_items.push_back(mk(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_exp.push_back(inside_r); dir_has_exp.push_back(1);
        dir_items.push_back(mk(-4*ONE, 0, 0, 4*ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(4*ONE, 0, 0, -4*ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(0, -4*ONE, 0, ONE, 4*ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(0, ONE/2, 9*ONE, ONE, 0, -9*ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, ONE, ONE,
                               -ONE, -ONE, -ONE, ONE, 2*ONE, 2*ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);
        dir_items.push_back(mk(-3*ONE, 0, 0, 3*ONE, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE));
        dir_has_exp.push_back(0); dir_exp.push_back(miss_r);

        foreach (dir_items[k]) send_item(dir_items[k], dir_has_exp[k], dir_exp[k]);
        s_valid <= 1'b0;

        // random phases, threshold rewritten while idle
        for (int ph = 0; ph < 6; ph++) begin
            wait (pending_hits.size() == 0);
            repeat (LATENCY + 4) @(posedge aclk);
            case (ph)
                0: write_threshold(16'd0);
                1: write_threshold(16'hFFFF);
                2: write_threshold(16'd1);
                3: write_threshold(16'($urandom));
                4: write_threshold(16'd256);
                default: write_threshold(THR_RESET);
            endcase
            send_idle_pct  = (ph == 1 || ph == 5) ? 87 : (ph == 3 ? 20 : 0);
            recv_stall_pct = (ph == 2 || ph == 5) ? 87 : (ph == 3 ? 20 : 0);
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                send_item(rand_item(), 0, miss_r);
                // hold off until the pipe drains, once
                if (ph == 0 && k == 100) begin
                    s_valid <= 1'b0;
                    wait (pending_hits.size() == 0);
                    @(posedge aclk);
                end
            end
            s_valid <= 1'b0;
        end

        recv_stall_pct = 0;
        wait (pending_hits.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

### segment_aabb_slab_intersect.f
rtl/core/sabi_pkg.sv
rtl/core/sabi_div.sv
rtl/core/sabi_lerp.sv
rtl/core/segment_aabb_slab_intersect.sv
verif/tb_segment_aabb_slab_intersect.sv
